// ===== rtl/round_robin_thread_scheduler_macros.svh =====
// Assertion helpers for the scheduler RTL, used by rrts_ctrl.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int unsigned IDX_W  = 6;
  localparam int unsigned TICK_W = 32;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_DELAY    = 2'd1,
    OP_REGISTER = 2'd2,
    OP_SCHEDULE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_IDLE_DELAY = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_SEARCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [TICK_W-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] thread_index;
    logic             switch_request;
    stat_t            status;
  } out_item_t;

  typedef struct packed {
    logic              do_tick;
    logic              do_delay;
    logic              do_reg;
    logic              load_tok;
    logic              shift_tok;
    logic [IDX_W-1:0]  tgt_idx;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  tc;
    logic [TICK_W-1:0] ticks;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rrts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [rrts_pkg::IDX_W-1:0] cell_idx,
  input  rrts_pkg::cell_ctrl_t     ctrl,
  input  logic                     tok_in,
  output logic                     tok_out,
  output logic                     wrap_out,
  output logic                     ready_out,
  output logic                     hit_out
);
  import rrts_pkg::*;

  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  logic              ready_r, ready_nxt;
  logic              tok_r, tok_nxt;
  logic              in_table, is_tgt, is_last;

  assign in_table = cell_idx < ctrl.tc;
  assign is_tgt   = cell_idx == ctrl.tgt_idx;
  assign is_last  = cell_idx == (ctrl.tc - IDX_W'(1));

  always_comb begin
    timeout_nxt = timeout_r;
    ready_nxt   = ready_r;
    if (ctrl.do_tick && in_table && (timeout_r != '0)) begin
      timeout_nxt = timeout_r - TICK_W'(1);
      if (timeout_r == TICK_W'(1)) begin
        ready_nxt = 1'b1;
      end
    end
    if (ctrl.do_delay && is_tgt) begin
      timeout_nxt = ctrl.ticks;
      ready_nxt   = 1'b0;
    end
    if (ctrl.do_reg && is_tgt) begin
      ready_nxt = 1'b1;
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    if (ctrl.load_tok) begin
      tok_nxt = (cell_idx == ctrl.start_idx);
    end else if (ctrl.shift_tok) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
      ready_r   <= 1'b0;
      tok_r     <= 1'b0;
    end else begin
      timeout_r <= timeout_nxt;
      ready_r   <= ready_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign wrap_out  = tok_r & is_last;
  assign ready_out = ready_r;
  assign hit_out   = tok_r & ready_r;

endmodule

`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_thread_scheduler_macros.svh"

module rrts_ctrl #(
  parameter int unsigned MAX_THREADS = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrts_pkg::out_item_t  out_data,
  input  logic                 ready_any,
  input  logic                 hit_any,
  output rrts_pkg::cell_ctrl_t cell_ctrl
);
  import rrts_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [IDX_W-1:0]  tc_r, tc_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              run_r, run_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_accept, out_free, table_full, idle_delay;
  logic [IDX_W-1:0]  cur_inc, pos_inc, start_idx, pick;

  assign in_accept  = in_valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign table_full = tc_r >= IDX_W'(MAX_THREADS);
  assign idle_delay = (op_r == OP_DELAY) && (cur_r == '0);
  assign cur_inc    = cur_r + IDX_W'(1);
  assign pos_inc    = pos_r + IDX_W'(1);
  assign start_idx  = (cur_inc >= tc_r) ? IDX_W'(1) : cur_inc;
  assign pick       = hit_any ? pos_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (op_r == OP_REGISTER || idle_delay) state_nxt = S_EMIT;
        else state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit_any || !ready_any) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs to the handshake and the cell row
  always_comb begin
    in_stall            = (state_r != S_IDLE);
    cell_ctrl           = '0;
    cell_ctrl.tgt_idx   = (op_r == OP_DELAY) ? cur_r : tc_r;
    cell_ctrl.start_idx = start_idx;
    cell_ctrl.tc        = tc_r;
    cell_ctrl.ticks     = ticks_r;
    case (state_r)
      S_APPLY: begin
        cell_ctrl.do_reg   = (op_r == OP_REGISTER) && !table_full;
        cell_ctrl.do_tick  = (op_r == OP_TICK);
        cell_ctrl.do_delay = (op_r == OP_DELAY) && !idle_delay;
        cell_ctrl.load_tok = (op_r != OP_REGISTER) && !idle_delay;
      end
      S_SEARCH: begin
        cell_ctrl.shift_tok = !hit_any && ready_any;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt        = op_r;
    ticks_nxt     = ticks_r;
    tc_nxt        = tc_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_data.operation;
          ticks_nxt = in_data.delay_ticks;
        end
      end
      S_APPLY: begin
        pos_nxt = start_idx;
        if (op_r == OP_REGISTER) begin
          if (table_full) begin
            res_nxt = '{thread_index: '0, switch_request: 1'b0, status: STAT_FULL};
          end else begin
            res_nxt = '{thread_index: tc_r, switch_request: 1'b0, status: STAT_OK};
            tc_nxt  = tc_r + IDX_W'(1);
          end
        end else if (idle_delay) begin
          res_nxt = '{thread_index: cur_r, switch_request: 1'b0, status: STAT_IDLE_DELAY};
        end
      end
      S_SEARCH: begin
        if (hit_any || !ready_any) begin
          res_nxt = '{thread_index: pick,
                      switch_request: (!run_r || (pick != cur_r)),
                      status: STAT_OK};
          cur_nxt = pick;
          run_nxt = 1'b1;
        end else begin
          pos_nxt = (pos_inc >= tc_r) ? IDX_W'(1) : pos_inc;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= '0;
      cur_r       <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      cur_r       <= cur_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ticks_r    <= ticks_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRTS_ASSERT_IMPL(a_tc_bound, clk, rst_n, 1'b1, tc_r <= IDX_W'(MAX_THREADS))
  `RRTS_ASSERT_IMPL(a_cur_in_table, clk, rst_n, run_r && (cur_r != '0), cur_r < tc_r)
  `RRTS_ASSERT_NEXT(a_hit_selects_worker, clk, rst_n,
                    (state_r == S_SEARCH) && hit_any, run_r && (cur_r != '0))

endmodule

`default_nettype wire

// ===== rtl/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Round-robin thread scheduler: idle thread at index 0, workers at 1..MAX_THREADS-1, each
// worker a cell in a row holding its ready bit and timeout counter. One transaction in gives
// one transaction out. Register and delay-by-idle go from the apply state straight to the
// emit state. Tick, delay and schedule first run a search: a token visits the cells, one cell
// per cycle, from the cell after the running thread until it meets a ready worker, at most
// MAX_THREADS-1 cells; with no worker ready, it visits one cell. Ticks decrement all timeouts
// together, in the apply state. The result sits in an output register while the next
// transaction is accepted and processed; a following result that finds the register still
// stalled waits, and the input stays stalled until the register is taken.

module round_robin_thread_scheduler #(
  parameter int unsigned MAX_THREADS = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rrts_pkg::out_item_t out_data
);
  import rrts_pkg::*;

  localparam int unsigned NW = MAX_THREADS - 1;

  cell_ctrl_t    cell_ctrl;
  logic [NW-1:0] tok_vec, wrap_vec, ready_vec, hit_vec, chain_in;
  logic          wrap_any, ready_any, hit_any;

  assign wrap_any  = |wrap_vec;
  assign ready_any = |ready_vec;
  assign hit_any   = |hit_vec;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign chain_in[g] = wrap_any;
    end else begin : g_rest
      assign chain_in[g] = tok_vec[g-1];
    end

    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g + 1)),
      .ctrl      (cell_ctrl),
      .tok_in    (chain_in[g]),
      .tok_out   (tok_vec[g]),
      .wrap_out  (wrap_vec[g]),
      .ready_out (ready_vec[g]),
      .hit_out   (hit_vec[g])
    );
  end

  rrts_ctrl #(
    .MAX_THREADS (MAX_THREADS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ready_any (ready_any),
    .hit_any   (hit_any),
    .cell_ctrl (cell_ctrl)
  );

endmodule

`default_nettype wire

// ===== tb/tb_round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int unsigned TB_MAX_THREADS = 33;
  localparam int unsigned WORKERS        = 32;
  localparam int          CYCLE_LIMIT    = 400000;

  class sched_scoreboard;
    int unsigned thr_count;
    bit [31:0]   ready_bits;
    int unsigned running_idx;
    bit          ran_once;
    bit [31:0]   wake_count [WORKERS];
    out_item_t   expected_results [$];
    int          errors;

    function new();
      thr_count   = 0;
      ready_bits  = '0;
      running_idx = 0;
      ran_once    = 1'b0;
      errors      = 0;
      foreach (wake_count[i]) wake_count[i] = '0;
    endfunction

    function out_item_t pick_next();
      out_item_t   r;
      int unsigned pick;
      int unsigned prev;
      int unsigned idx;
      bit          found;
      r     = '0;
      pick  = 0;
      prev  = running_idx;
      found = 1'b0;
      if (ready_bits != '0) begin
        idx = running_idx;
        for (int k = 0; k < WORKERS + 1 && !found; k++) begin
          idx++;
          if (idx >= thr_count || idx > WORKERS) idx = 1;
          if (ready_bits[idx-1]) found = 1'b1;
        end
        if (found) pick = idx;
      end
      r.thread_index   = 6'(pick);
      r.switch_request = !ran_once || (pick != prev);
      r.status         = STAT_OK;
      running_idx      = pick;
      ran_once         = 1'b1;
      return r;
    endfunction

    function out_item_t predict_result(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.operation)
        OP_REGISTER: begin
          if (thr_count < TB_MAX_THREADS && thr_count <= WORKERS) begin
            if (thr_count > 0) ready_bits[thr_count-1] = 1'b1;
            r.thread_index = 6'(thr_count);
            r.status       = STAT_OK;
            thr_count++;
          end else begin
            r.status = STAT_FULL;
          end
          return r;
        end
        OP_DELAY: begin
          if (running_idx == 0 || running_idx > WORKERS) begin
            r.thread_index = 6'(running_idx);
            r.status       = STAT_IDLE_DELAY;
            return r;
          end
          wake_count[running_idx-1] = it.delay_ticks;
          ready_bits[running_idx-1] = 1'b0;
        end
        OP_TICK: begin
          for (int n = 1; n < thr_count && n <= WORKERS; n++) begin
            if (wake_count[n-1] != '0) begin
              wake_count[n-1]--;
              if (wake_count[n-1] == '0) ready_bits[n-1] = 1'b1;
            end
          end
        end
        default: ;
      endcase
      return pick_next();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_input(in_item_t it);
      expected_results.push_back(predict_result(it));
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction idx %0d sw %0d st %0d",
                                  got.thread_index, got.switch_request, got.status));
        return;
      end
      want = expected_results.pop_front();
      if (got.thread_index !== want.thread_index || got.switch_request !== want.switch_request ||
          got.status !== want.status)
        report_mismatch($sformatf("got idx %0d sw %0d st %0d, want idx %0d sw %0d st %0d",
                                  got.thread_index, got.switch_request, got.status,
                                  want.thread_index, want.switch_request, want.status));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sched_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int cycle_count = 0;

  round_robin_thread_scheduler #(
    .MAX_THREADS(TB_MAX_THREADS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // result side: check accepted transactions, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      out_stall <= (stall_left > 0);
    end
  end

  function automatic in_item_t mk_item(op_t op, logic [31:0] ticks);
    in_item_t it;
    it.operation   = op;
    it.delay_ticks = ticks;
    return it;
  endfunction

  function automatic in_item_t rand_item(int reg_pct);
    int          w;
    int          sel;
    op_t         op;
    logic [31:0] ticks;
    w = $urandom_range(0, 99);
    if (w < reg_pct) op = OP_REGISTER;
    else if (w < reg_pct + 35) op = OP_TICK;
    else if (w < reg_pct + 65) op = OP_DELAY;
    else op = OP_SCHEDULE;
    sel = $urandom_range(0, 31);
    case (sel)
      0:       ticks = '0;
      1:       ticks = $urandom;
      2:       ticks = 32'hFFFF_FFFF;
      3, 4, 5, 6, 7: ticks = $urandom_range(5, 60);
      default: ticks = $urandom_range(1, 4);
    endcase
    return mk_item(op, ticks);
  endfunction

  task automatic send_item(in_item_t it);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t directed [$];
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      mk_item(OP_DELAY,    32'd5),          // delay before anything ran
      mk_item(OP_SCHEDULE, 32'd0),          // empty table
      mk_item(OP_TICK,     32'd0),
      mk_item(OP_REGISTER, 32'd0),          // idle thread
      mk_item(OP_SCHEDULE, 32'd0),
      mk_item(OP_REGISTER, 32'd0),
      mk_item(OP_REGISTER, 32'd0),
      mk_item(OP_REGISTER, 32'd0),
      mk_item(OP_TICK,     32'd0),
      mk_item(OP_DELAY,    32'd0),          // never woken again
      mk_item(OP_SCHEDULE, 32'd0),
      mk_item(OP_DELAY,    32'hFFFF_FFFF),
      mk_item(OP_DELAY,    32'd2),
      mk_item(OP_DELAY,    32'd7),          // delay from idle
      mk_item(OP_TICK,     32'd0),
      mk_item(OP_TICK,     32'd0),
      mk_item(OP_SCHEDULE, 32'd0),
      mk_item(OP_DELAY,    32'd1),
      mk_item(OP_TICK,     32'hFFFF_FFFF),
      mk_item(OP_REGISTER, 32'hFFFF_FFFF),
      mk_item(OP_SCHEDULE, 32'hAAAA_5555),
      mk_item(OP_TICK,     32'h5555_AAAA)
    };
    foreach (directed[i]) send_item(directed[i]);

    repeat (200) send_item(rand_item(3));
    drain_results();

    // fill the table, then overflow it
    while (sb.thr_count < TB_MAX_THREADS) begin
      send_item(mk_item(OP_REGISTER, $urandom));
      if ($urandom_range(0, 3) == 0) send_item(mk_item(OP_SCHEDULE, $urandom));
    end
    repeat (3) send_item(mk_item(OP_REGISTER, $urandom));

    repeat (250) send_item(rand_item(4));

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (100) send_item(rand_item(4));

    drain_results();
    repeat (64) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_cell.sv
rtl/rrts_ctrl.sv
rtl/round_robin_thread_scheduler.sv
tb/tb_round_robin_thread_scheduler.sv
